### src/loser_tree_kway_merge_core_macros.svh
// Assertion helpers used by the merge core.
`ifndef LOSER_TREE_KWAY_MERGE_CORE_MACROS_SVH
`define LOSER_TREE_KWAY_MERGE_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define LTKM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define LTKM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/ltkm_pkg.sv
`timescale 1ns / 1ps
package ltkm_pkg;

  localparam int MAX_LANES = 8;
  localparam int LANE_W    = $clog2(MAX_LANES);
  localparam int NODE_W    = LANE_W + 1;
  localparam int CNT_W     = 4;

  typedef enum logic [1:0] {
    FN_LOAD    = 2'd0,
    FN_BUILD   = 2'd1,
    FN_REPLACE = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_mid;
    logic [31:0] key_lo;
    logic [31:0] owner;
    logic [31:0] size;
    logic [63:0] offset;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_t;

endpackage

### src/ltkm_ram.sv
`timescale 1ns / 1ps
module ltkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ltkm_cmp.sv
`timescale 1ns / 1ps
module ltkm_cmp (
  input  ltkm_pkg::rec_t a,
  input  ltkm_pkg::rec_t b,
  output ltkm_pkg::cmp_t res
);

  logic         za, zb;
  logic [159:0] ka, kb;

  always_comb begin
    za = (a.size == 32'd0);
    zb = (b.size == 32'd0);
    ka = {a.key_hi, a.key_mid, a.key_lo};
    kb = {b.key_hi, b.key_mid, b.key_lo};
    // exhausted streams rank above every live record
    if (za || zb) begin
      res.lt = !za && zb;
      res.gt = za && !zb;
    end else begin
      res.lt = (ka < kb);
      res.gt = (ka > kb);
    end
  end

endmodule

### src/loser_tree_kway_merge_core.sv
`timescale 1ns / 1ps
// K-way merge of up to eight sorted record streams kept in a loser tree.
// A load (func 0) stores a lane head and gives no result. A build (func 1)
// plays every internal node bottom up through one shared 160-bit comparator:
// each node reads the left and right child winners, then both lane records,
// and compares; with n = 1 it only reads lane 0. The winner then goes to the
// output register. A replace (func 2) overwrites the winner lane's record and
// replays its path, each tree level a loser read, a record read and a compare,
// then emits. The record memory has one read port, so these reads follow one
// another. Input is stalled while an item is at work; a result waiting in
// the output register does not block the next input until a new result is ready.
// num_lanes is taken as 1 when zero and as 8 above 8. all_done flags a
// winner with block size zero: every stream is exhausted.
`include "loser_tree_kway_merge_core_macros.svh"
module loser_tree_kway_merge_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [2:0]  lane,
  input  logic [63:0] key_hi,
  input  logic [63:0] key_mid,
  input  logic [31:0] key_lo,
  input  logic [31:0] owner_id,
  input  logic [31:0] block_size,
  input  logic [63:0] block_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  winner_lane,
  output logic [63:0] out_key_hi,
  output logic [63:0] out_key_mid,
  output logic [31:0] out_key_lo,
  output logic [31:0] out_owner_id,
  output logic [31:0] out_block_size,
  output logic [63:0] out_block_offset,
  output logic        all_done
);

  localparam int LW = ltkm_pkg::LANE_W;
  localparam int NW = ltkm_pkg::NODE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_B_WL, S_B_WR, S_B_RA, S_B_RB, S_B_CMP,
    S_R_LOS, S_R_REC, S_R_CMP, S_F_REC, S_F_CAP, S_EMIT
  } state_t;

  state_t              state;
  logic [ltkm_pkg::CNT_W-1:0] num_lanes;
  logic [NW-1:0]       n_eff;
  logic [LW-1:0]       k, node, lane_a, lane_b, winner_index, res_lane;
  ltkm_pkg::rec_t      reg_a, res_rec, in_rec;
  ltkm_pkg::cmp_t      cmp;
  logic [NW-1:0]       l_idx, r_idx, sum_wn;
  logic                accept, out_take, emit_fire;

  // memories
  logic                rec_we;
  logic [LW-1:0]       rec_waddr, rec_raddr;
  ltkm_pkg::rec_t      rec_wdata, rec_rdata;
  logic                los_we;
  logic [LW-1:0]       los_waddr, los_raddr, los_wdata, los_rdata;
  logic                win_we;
  logic [LW-1:0]       win_waddr, win_raddr, win_wdata, win_rdata;

  ltkm_ram #(.WIDTH(ltkm_pkg::REC_W), .DEPTH(ltkm_pkg::MAX_LANES)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );
  ltkm_ram #(.WIDTH(LW), .DEPTH(ltkm_pkg::MAX_LANES)) u_los (
    .clk(clk), .we(los_we), .waddr(los_waddr), .wdata(los_wdata),
    .raddr(los_raddr), .rdata(los_rdata)
  );
  ltkm_ram #(.WIDTH(LW), .DEPTH(ltkm_pkg::MAX_LANES)) u_win (
    .clk(clk), .we(win_we), .waddr(win_waddr), .wdata(win_wdata),
    .raddr(win_raddr), .rdata(win_rdata)
  );

  // shared comparator: held record against the record just read
  ltkm_cmp u_cmp (.a(reg_a), .b(rec_rdata), .res(cmp));

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  // load the output register once it is free or being taken this cycle
  assign emit_fire = (state == S_EMIT) && (!out_valid || out_take);

  always_comb begin
    in_rec.key_hi  = key_hi;
    in_rec.key_mid = key_mid;
    in_rec.key_lo  = key_lo;
    in_rec.owner   = owner_id;
    in_rec.size    = block_size;
    in_rec.offset  = block_offset;
  end

  // clamp the lane count
  always_comb begin
    if (num_lanes == '0) begin
      n_eff = NW'(1);
    end else if (num_lanes > ltkm_pkg::CNT_W'(ltkm_pkg::MAX_LANES)) begin
      n_eff = NW'(ltkm_pkg::MAX_LANES);
    end else begin
      n_eff = NW'(num_lanes);
    end
  end

  assign l_idx  = {k, 1'b0};
  assign r_idx  = {k, 1'b1};
  assign sum_wn = NW'(winner_index) + n_eff;

  // memory ports
  always_comb begin
    rec_we    = accept && ((func == ltkm_pkg::FN_LOAD) || (func == ltkm_pkg::FN_REPLACE));
    rec_waddr = (func == ltkm_pkg::FN_LOAD) ? lane : winner_index;
    rec_wdata = in_rec;
    rec_raddr = lane_a;
    win_raddr = l_idx[LW-1:0];
    los_raddr = node;
    unique case (state)
      S_B_RB:  rec_raddr = lane_b;
      S_R_REC: rec_raddr = los_rdata;
      S_B_WR:  win_raddr = r_idx[LW-1:0];
      default: ;
    endcase
    // build: the higher-ranked record loses
    win_we    = (state == S_B_CMP);
    win_waddr = k;
    win_wdata = cmp.gt ? lane_b : lane_a;
    los_we    = (state == S_B_CMP) || ((state == S_R_CMP) && !cmp.lt);
    los_waddr = (state == S_B_CMP) ? k : node;
    los_wdata = (state == S_B_CMP) ? (cmp.gt ? lane_a : lane_b) : lane_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      num_lanes    <= ltkm_pkg::CNT_W'(ltkm_pkg::MAX_LANES);
      winner_index <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_lanes <= cfg_wdata;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (func == ltkm_pkg::FN_BUILD)) begin
            k      <= LW'(n_eff - NW'(1));
            lane_a <= '0;
            state  <= (n_eff == NW'(1)) ? S_F_REC : S_B_WL;
          end else if (accept && (func == ltkm_pkg::FN_REPLACE)) begin
            // the new record starts the climb from its leaf
            reg_a  <= in_rec;
            lane_a <= winner_index;
            node   <= sum_wn[NW-1:1];
            if (sum_wn[NW-1:1] == '0) begin
              res_rec  <= in_rec;
              res_lane <= winner_index;
              state    <= S_EMIT;
            end else begin
              state <= S_R_LOS;
            end
          end
        end
        S_B_WL: state <= S_B_WR;
        S_B_WR: begin
          lane_a <= (l_idx >= n_eff) ? LW'(l_idx - n_eff) : win_rdata;
          state  <= S_B_RA;
        end
        S_B_RA: begin
          lane_b <= (r_idx >= n_eff) ? LW'(r_idx - n_eff) : win_rdata;
          state  <= S_B_RB;
        end
        S_B_RB: begin
          reg_a <= rec_rdata;
          state <= S_B_CMP;
        end
        S_B_CMP: begin
          if (k == LW'(1)) begin
            winner_index <= cmp.gt ? lane_b : lane_a;
            res_lane     <= cmp.gt ? lane_b : lane_a;
            res_rec      <= cmp.gt ? rec_rdata : reg_a;
            state        <= S_EMIT;
          end else begin
            k     <= k - LW'(1);
            state <= S_B_WL;
          end
        end
        S_R_LOS: state <= S_R_REC;
        S_R_REC: begin
          lane_b <= los_rdata;
          state  <= S_R_CMP;
        end
        S_R_CMP: begin
          // stored loser takes over on a tie
          if (!cmp.lt) begin
            lane_a <= lane_b;
            reg_a  <= rec_rdata;
          end
          node <= node >> 1;
          if ((node >> 1) == '0) begin
            winner_index <= cmp.lt ? lane_a : lane_b;
            res_lane     <= cmp.lt ? lane_a : lane_b;
            res_rec      <= cmp.lt ? reg_a : rec_rdata;
            state        <= S_EMIT;
          end else begin
            state <= S_R_LOS;
          end
        end
        S_F_REC: state <= S_F_CAP;
        S_F_CAP: begin
          winner_index <= '0;
          res_lane     <= '0;
          res_rec      <= rec_rdata;
          state        <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (emit_fire) begin
            winner_lane      <= res_lane;
            out_key_hi       <= res_rec.key_hi;
            out_key_mid      <= res_rec.key_mid;
            out_key_lo       <= res_rec.key_lo;
            out_owner_id     <= res_rec.owner;
            out_block_size   <= res_rec.size;
            out_block_offset <= res_rec.offset;
            all_done         <= (res_rec.size == 32'd0);
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LTKM_ASSERT(a_busy_stalls, (state != S_IDLE) |-> in_stall, "busy sequencer must stall input")
  `LTKM_ASSERT(a_build_starts, (accept && (func == ltkm_pkg::FN_BUILD)) |=> (state != S_IDLE), "build did not start")
  `LTKM_ASSERT(a_replay_node, (state == S_R_CMP) |-> (node != '0), "replay at root slot")
  `LTKM_ASSERT_ALWAYS(a_reset_idle, rst |=> ((state == S_IDLE) && !out_valid), "reset did not clear control")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import ltkm_pkg::*;

  // One input transfer as the sender sees it.
  typedef struct {
    func_t      fn;
    logic [2:0] ln;
    rec_t       rec;
  } merge_item_t;

  // One emitted winner.
  typedef struct packed {
    logic [2:0] ln;
    rec_t       rec;
    logic       done;
  } winner_t;

  // Mirror of the merge state: lane heads, loser nodes, current winner and lane count.
  // Loads, builds and replaces update the mirror; build and replace queue the winner they produce.
  class merge_scoreboard;
    rec_t        heads[MAX_LANES];
    int unsigned losers[MAX_LANES];
    int unsigned win;
    int unsigned lane_reg;
    winner_t     pending_winners[$];
    int          errors;

    function new();
      win = 0;
      lane_reg = 8;
      errors = 0;
    endfunction

    function void set_lanes(int unsigned v);
      lane_reg = v & 15;
    endfunction

    function int unsigned active_lanes();
      if (lane_reg < 1) return 1;
      if (lane_reg > MAX_LANES) return MAX_LANES;
      return lane_reg;
    endfunction

    // -1, 0, 1: record a below, equal to, above record b; exhausted ranks last
    function int order(int unsigned a, int unsigned b);
      logic za, zb;
      logic [159:0] ka, kb;
      za = heads[a].size == 0;
      zb = heads[b].size == 0;
      if (za || zb) begin
        if (za && zb) return 0;
        return za ? 1 : -1;
      end
      ka = {heads[a].key_hi, heads[a].key_mid, heads[a].key_lo};
      kb = {heads[b].key_hi, heads[b].key_mid, heads[b].key_lo};
      if (ka == kb) return 0;
      return (ka < kb) ? -1 : 1;
    endfunction

    // play the subtree under node k; a tie goes left
    function int unsigned play(int unsigned k, int unsigned n);
      int unsigned l, r;
      l = 2 * k;
      r = l + 1;
      l = (l >= n) ? l - n : play(l, n);
      r = (r >= n) ? r - n : play(r, n);
      if (order(l, r) > 0) begin
        losers[k] = l;
        return r;
      end
      losers[k] = r;
      return l;
    endfunction

    // walk from leaf to root; the stored loser wins a tie
    function void climb(int unsigned w, int unsigned n);
      int unsigned node, cur, other;
      node = (w + n) / 2;
      cur = w;
      while (node > 0) begin
        other = losers[node] % MAX_LANES;
        if (order(cur, other) >= 0) begin
          losers[node] = cur;
          cur = other;
        end
        node = node / 2;
      end
      losers[0] = cur;
      win = cur;
    endfunction

    function void push_winner();
      winner_t r;
      int unsigned w;
      w = win % MAX_LANES;
      r.ln = w[2:0];
      r.rec = heads[w];
      r.done = heads[w].size == 0;
      pending_winners.insert(pending_winners.size(), r);
    endfunction

    function void note_input(merge_item_t it);
      int unsigned n;
      n = active_lanes();
      case (it.fn)
        FN_LOAD: heads[it.ln] = it.rec;
        FN_BUILD: begin
          win = (n == 1) ? 0 : play(1, n);
          losers[0] = win;
          push_winner();
        end
        FN_REPLACE: begin
          heads[win % MAX_LANES] = it.rec;
          climb(win % MAX_LANES, n);
          push_winner();
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(winner_t got);
      winner_t w;
      if (pending_winners.size() == 0) begin
        report($sformatf("winner lane %0d emitted with nothing expected", got.ln));
        return;
      end
      w = pending_winners.pop_front();
      if (got.ln !== w.ln)
        report($sformatf("winner_lane %0d, expected %0d", got.ln, w.ln));
      if (got.rec.key_hi !== w.rec.key_hi)
        report($sformatf("key_hi %h, expected %h", got.rec.key_hi, w.rec.key_hi));
      if (got.rec.key_mid !== w.rec.key_mid)
        report($sformatf("key_mid %h, expected %h", got.rec.key_mid, w.rec.key_mid));
      if (got.rec.key_lo !== w.rec.key_lo)
        report($sformatf("key_lo %h, expected %h", got.rec.key_lo, w.rec.key_lo));
      if (got.rec.owner !== w.rec.owner)
        report($sformatf("owner_id %h, expected %h", got.rec.owner, w.rec.owner));
      if (got.rec.size !== w.rec.size)
        report($sformatf("block_size %h, expected %h", got.rec.size, w.rec.size));
      if (got.rec.offset !== w.rec.offset)
        report($sformatf("block_offset %h, expected %h", got.rec.offset, w.rec.offset));
      if (got.done !== w.done)
        report($sformatf("all_done %b, expected %b", got.done, w.done));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [3:0]  cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  func = 0;
  logic [2:0]  lane = 0;
  logic [63:0] key_hi = 0;
  logic [63:0] key_mid = 0;
  logic [31:0] key_lo = 0;
  logic [31:0] owner_id = 0;
  logic [31:0] block_size = 0;
  logic [63:0] block_offset = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  winner_lane;
  logic [63:0] out_key_hi;
  logic [63:0] out_key_mid;
  logic [31:0] out_key_lo;
  logic [31:0] out_owner_id;
  logic [31:0] out_block_size;
  logic [63:0] out_block_offset;
  logic        all_done;

  merge_scoreboard sb = new();
  int items_sent = 0;
  int burst_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;

  loser_tree_kway_merge_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .lane(lane),
    .key_hi(key_hi), .key_mid(key_mid), .key_lo(key_lo),
    .owner_id(owner_id), .block_size(block_size), .block_offset(block_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .winner_lane(winner_lane),
    .out_key_hi(out_key_hi), .out_key_mid(out_key_mid), .out_key_lo(out_key_lo),
    .out_owner_id(out_owner_id), .out_block_size(out_block_size),
    .out_block_offset(out_block_offset), .all_done(all_done)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver stall: the pattern switches now and then, and a long hold-off recurs
  // so the output register fills and the block stalls its input.
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 4);
    if (rst) begin
      out_stall = 0;
    end else if (rx_cycle % 5000 >= 4600) begin
      out_stall = 1;
    end else begin
      case (rx_mode)
        0: out_stall = 0;
        1: out_stall = ($urandom_range(0, 3) == 0);
        2: out_stall = ($urandom_range(0, 3) != 0);
        3: out_stall = (rx_cycle % 5 < 2);
        default: out_stall = ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Check every result transfer against the oldest predicted winner.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{winner_lane, '{out_key_hi, out_key_mid, out_key_lo, out_owner_id,
                                       out_block_size, out_block_offset}, all_done});
  end

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return '1;
      2: return 64'($urandom_range(0, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic rec_t rand_rec(bit live);
    rec_t r;
    logic [63:0] lo;
    r.key_hi = pick64();
    r.key_mid = pick64();
    lo = pick64();
    r.key_lo = lo[31:0];
    r.owner = $urandom;
    r.offset = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: r.size = live ? 32'd1 : 32'd0;
      1: r.size = '1;
      default: r.size = $urandom | 32'd1;
    endcase
    return r;
  endfunction

  // Offer one item in bursts with random gaps; hold it until the block takes it.
  task automatic send(func_t fn, logic [2:0] ln, rec_t rec);
    merge_item_t it;
    int gap;
    it = '{fn, ln, rec};
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid = 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    func = fn;
    lane = ln;
    {key_hi, key_mid, key_lo, owner_id, block_size, block_offset} = rec;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
  endtask

  // Drop valid and drain; loads give no result, so leave the block time to settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending_winners.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_lanes(logic [3:0] v);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(posedge clk);
    sb.set_lanes(v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  // Next record of the winner's stream: mostly at or above the current head.
  function automatic rec_t next_rec();
    rec_t r, cur;
    logic [159:0] k;
    cur = sb.heads[sb.win % MAX_LANES];
    r = rand_rec(1);
    k = {cur.key_hi, cur.key_mid, cur.key_lo};
    case ($urandom_range(0, 5))
      0: ;
      1: k = k + 160'($urandom_range(1, 3));
      2: k = k + {$urandom, $urandom};
      3: k = k + {$urandom, 128'd0};
      4: k = {r.key_hi, r.key_mid, r.key_lo};
      default: k = k + 160'($urandom);
    endcase
    {r.key_hi, r.key_mid, r.key_lo} = k;
    if ($urandom_range(0, 5) == 0) r.size = 0;
    return r;
  endfunction

  // Load the heads, build, then replace the winner for up to steps rounds or until the
  // streams run dry, with some noise: stray loads, rebuilds and the unused function code.
  task automatic merge_run(int steps);
    int unsigned n;
    n = sb.active_lanes();
    for (int i = 0; i < MAX_LANES; i++)
      if (i < n || $urandom_range(0, 3) == 0) send(FN_LOAD, 3'(i), rand_rec(1));
    send(FN_BUILD, 3'($urandom), rand_rec(0));
    for (int s = 0; s < steps; s++) begin
      if (sb.heads[sb.win % MAX_LANES].size == 0 && $urandom_range(0, 3) != 0) break;
      case ($urandom_range(0, 19))
        0: send(FN_NONE, 3'($urandom), rand_rec(0));
        1: send(FN_LOAD, 3'($urandom), rand_rec(0));
        2: send(FN_BUILD, 3'($urandom), rand_rec(0));
        default: send(FN_REPLACE, 3'($urandom), next_rec());
      endcase
    end
  endtask

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rec_t r;
    logic [3:0] plan[12] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd9, 4'd2, 4'd3, 4'd5,
                             4'd4, 4'd6, 4'd7, 4'd8};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    write_lanes(4'd8);

    // Directed: key extremes, a left-wins tie, an exhausted lane, max fields.
    r = '{64'd0, 64'd0, 32'd0, 32'd0, 32'd1, 64'd0};
    send(FN_LOAD, 3'd0, r);
    r.size = 32'd5;
    send(FN_LOAD, 3'd1, r);
    send(FN_LOAD, 3'd2, '{'1, '1, '1, '1, '1, '1});
    send(FN_LOAD, 3'd3, '{64'd0, 64'd0, 32'd0, 32'd7, 32'd0, 64'd9});
    send(FN_LOAD, 3'd4, '{'1, '1, '1, 32'd0, 32'd1, 64'd0});
    for (int i = 5; i < MAX_LANES; i++) send(FN_LOAD, 3'(i), rand_rec(1));
    send(FN_BUILD, 3'd0, r);
    // same key again: the stored loser takes the win
    send(FN_REPLACE, 3'd7, '{64'd0, 64'd0, 32'd0, 32'd3, 32'd2, 64'd4});
    send(FN_REPLACE, 3'd0, '{'1, '1, '1, 32'd1, 32'd0, '1});
    send(FN_NONE, 3'd5, rand_rec(1));
    // all streams exhausted
    for (int i = 0; i < MAX_LANES; i++) send(FN_LOAD, 3'(i), '{'1, 64'd0, '1, 32'd0, 32'd0, 64'd0});
    send(FN_BUILD, 3'd0, r);
    send(FN_LOAD, 3'd7, rand_rec(1));
    send(FN_BUILD, 3'd3, r);
    drain();

    for (int p = 0; items_sent < 1650; p++) begin
      write_lanes(p < 12 ? plan[p] : 4'($urandom_range(0, 15)));
      merge_run($urandom_range(20, 60));
      drain();
    end

    if (sb.pending_winners.size() == 0 && sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/ltkm_pkg.sv
src/ltkm_ram.sv
src/ltkm_cmp.sv
src/loser_tree_kway_merge_core.sv
tb/tb.sv
